// ----- rtl/gvl_pkg.sv -----
// shared types, constants and term tables for the gravity leveling block
// no dependencies; imported by every module of the block
package gvl_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int STAMP_BITS_DEF = 48;

  localparam int MIN_W      = 24;
  localparam int DUR_W      = 40;
  localparam int SUM_W      = 56;
  localparam int MUL_W      = 33;
  localparam int ACC_W      = 68;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 40;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_SAMPLES    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CALIB_DURATION = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PASS_BEFORE    = 2'd2;

  localparam logic [MIN_W-1:0] MIN_SAMPLES_RST    = 24'd800;
  localparam logic [DUR_W-1:0] CALIB_DURATION_RST = 40'd2000000;

  localparam logic OP_IMU   = 1'b0;
  localparam logic OP_POINT = 1'b1;

  localparam logic [31:0] ONE_Q30   = 32'h4000_0000;
  localparam logic [31:0] HALF_Q30  = 32'h2000_0000;
  localparam logic [63:0] NORM_LOW  = 64'h0400_0000_0000_0000;
  localparam logic [63:0] NORM_HIGH = 64'h2400_0000_0000_0000;

  typedef enum logic [4:0] {
    S_IDLE, S_ACCUM, S_CHECK, S_MAX, S_NORM, S_SQ, S_SQRT_N, S_LSQ, S_SQRT_L,
    S_QDIV, S_SIGN, S_MAT, S_ROT, S_OTOT, S_OPROD, S_ONSQ, S_SQRT_O, S_ODIV, S_FINISH
  } state_e;

  typedef enum logic [1:0] {Q_W, Q_X, Q_Y, Q_ZERO} qsel_e;

  typedef struct packed {
    qsel_e a;
    qsel_e b;
    logic  neg;
  } mat_term_t;

  typedef struct packed {
    logic [1:0] bidx;
    logic       neg;
  } prod_term_t;

  typedef struct packed {
    logic en;
    logic clr;
    logic neg;
  } mac_ctl_t;

  // product terms of the rotation matrix of a quaternion with zero z
  function automatic mat_term_t mat_term(logic [3:0] ent, logic term);
    mat_term_t t;
    t = '{a: Q_ZERO, b: Q_ZERO, neg: 1'b0};
    unique case (ent)
      4'd0: if (!term) t = '{a: Q_Y, b: Q_Y, neg: 1'b0};
      4'd1: if (!term) t = '{a: Q_X, b: Q_Y, neg: 1'b0};
      4'd2: if (!term) t = '{a: Q_W, b: Q_Y, neg: 1'b0};
      4'd3: if (!term) t = '{a: Q_X, b: Q_Y, neg: 1'b0};
      4'd4: if (!term) t = '{a: Q_X, b: Q_X, neg: 1'b0};
      4'd5: if (!term) t = '{a: Q_W, b: Q_X, neg: 1'b1};
      4'd6: if (!term) t = '{a: Q_W, b: Q_Y, neg: 1'b1};
      4'd7: if (!term) t = '{a: Q_W, b: Q_X, neg: 1'b0};
      4'd8: t = term ? '{a: Q_Y, b: Q_Y, neg: 1'b0} : '{a: Q_X, b: Q_X, neg: 1'b0};
      default: t = '{a: Q_ZERO, b: Q_ZERO, neg: 1'b0};
    endcase
    return t;
  endfunction

  // hamilton product terms: term k uses level component k (w, x, y)
  function automatic prod_term_t prod_term(logic [1:0] row, logic [1:0] term);
    prod_term_t t;
    t = '{bidx: 2'd0, neg: 1'b0};
    unique case ({row, term})
      4'b00_00: t = '{bidx: 2'd0, neg: 1'b0};
      4'b00_01: t = '{bidx: 2'd1, neg: 1'b1};
      4'b00_10: t = '{bidx: 2'd2, neg: 1'b1};
      4'b01_00: t = '{bidx: 2'd1, neg: 1'b0};
      4'b01_01: t = '{bidx: 2'd0, neg: 1'b0};
      4'b01_10: t = '{bidx: 2'd3, neg: 1'b0};
      4'b10_00: t = '{bidx: 2'd2, neg: 1'b0};
      4'b10_01: t = '{bidx: 2'd3, neg: 1'b1};
      4'b10_10: t = '{bidx: 2'd0, neg: 1'b0};
      4'b11_00: t = '{bidx: 2'd3, neg: 1'b0};
      4'b11_01: t = '{bidx: 2'd2, neg: 1'b0};
      4'b11_10: t = '{bidx: 2'd1, neg: 1'b1};
      default:  t = '{bidx: 2'd0, neg: 1'b0};
    endcase
    return t;
  endfunction

endpackage

// ----- rtl/gvl_mac.sv -----
// shared signed multiply-accumulate unit
// depends on gvl_pkg for widths and the control struct
module gvl_mac import gvl_pkg::*; (
  input  logic                    clk_i,
  input  mac_ctl_t                ctl_i,
  input  logic signed [MUL_W-1:0] a_i,
  input  logic signed [MUL_W-1:0] b_i,
  output logic signed [ACC_W-1:0] acc_o
);

  logic signed [2*MUL_W-1:0] prod;
  logic signed [ACC_W-1:0]   term, base, acc_d, acc_q;

  always_comb begin
    prod  = a_i * b_i;
    term  = ACC_W'(prod);
    base  = ctl_i.clr ? '0 : acc_q;
    acc_d = ctl_i.neg ? base - term : base + term;
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.en) begin
      acc_q <= acc_d;
    end
  end

  assign acc_o = acc_q;

endmodule

// ----- rtl/gvl_isqrt.sv -----
// iterative 64-bit integer square root, one result bit per cycle
// depends on gvl_pkg (imported for house consistency)
module gvl_isqrt import gvl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] arg_i,
  output logic [31:0] root_o,
  output logic        done_o
);

  logic [63:0] v_q, r_q, b_q, sum;
  logic        busy_q, done_q, ge;

  always_comb begin
    sum = r_q + b_q;
    ge  = v_q >= sum;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
      end else if (busy_q && b_q[0]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      v_q <= arg_i;
      r_q <= '0;
      b_q <= 64'h4000_0000_0000_0000;
    end else if (busy_q) begin
      if (ge) begin
        v_q <= v_q - sum;
        r_q <= (r_q >> 1) + b_q;
      end else begin
        r_q <= r_q >> 1;
      end
      b_q <= b_q >> 2;
    end
  end

  assign root_o = r_q[31:0];
  assign done_o = done_q;

endmodule

// ----- rtl/gvl_div.sv -----
// iterative restoring divider, 64-bit numerator over 32-bit divisor, quotient below 2^32
// depends on gvl_pkg (imported for house consistency)
module gvl_div import gvl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] num_i,
  input  logic [31:0] den_i,
  output logic [31:0] quo_o,
  output logic        done_o
);

  logic [31:0] rem_q, num_q, quo_q, den_q;
  logic [4:0]  cnt_q;
  logic        busy_q, done_q, ge;
  logic [32:0] rem2, diff;

  always_comb begin
    rem2 = {rem_q, num_q[31]};
    diff = rem2 - {1'b0, den_q};
    ge   = rem2 >= {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (&cnt_q) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= num_i[63:32];
      num_q <= num_i[31:0];
      den_q <= den_i;
    end else if (busy_q) begin
      rem_q <= ge ? diff[31:0] : rem2[31:0];
      quo_q <= {quo_q[30:0], ge};
      num_q <= {num_q[30:0], 1'b0};
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

// ----- rtl/gravity_level_calibrate_rotate.sv -----
// gravity leveling block: calibration accumulators, sequencer and shared datapath
// depends on gvl_pkg, gvl_mac, gvl_isqrt and gvl_div
//
// Takes IMU samples (op 0) and points (op 1) one at a time; in_ready_o is high only
// while the sequencer is idle. Until calibrated, IMU accelerations are summed; once
// min_samples samples and calib_duration microseconds have gone by, the average
// direction is leveled onto +Z and every later item is rotated by that quaternion.
// All arithmetic goes through one 33x33 multiply-accumulate unit, a 32-step square
// root unit and a 32-step divider. A point uses only the MAC, for the 3x3 rotation.
// The work for a leveled IMU sample is set mostly by one square root and four
// divisions for the orientation normalize; a sample whose orientation norm is out
// of range skips them. The sample that triggers calibration adds normalizing shifts,
// two square roots, three divisions and a matrix build. The result is held in an
// output register, so a finished item waits there while the next is taken in; the
// sequencer holds its finish state until that register is free.
module gravity_level_calibrate_rotate import gvl_pkg::*; #(
  parameter int COUNT_BITS = COUNT_BITS_DEF,
  parameter int STAMP_BITS = STAMP_BITS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // configuration writes
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  // input items
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  op_i,
  input  logic [STAMP_BITS-1:0] stamp_i,
  input  logic signed [31:0]    vec_x_i,
  input  logic signed [31:0]    vec_y_i,
  input  logic signed [31:0]    vec_z_i,
  input  logic signed [31:0]    rate_x_i,
  input  logic signed [31:0]    rate_y_i,
  input  logic signed [31:0]    rate_z_i,
  input  logic signed [31:0]    orient_w_i,
  input  logic signed [31:0]    orient_x_i,
  input  logic signed [31:0]    orient_y_i,
  input  logic signed [31:0]    orient_z_i,
  // result items
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic                  kind_o,
  output logic signed [31:0]    out_x_o,
  output logic signed [31:0]    out_y_o,
  output logic signed [31:0]    out_z_o,
  output logic signed [31:0]    out_rate_x_o,
  output logic signed [31:0]    out_rate_y_o,
  output logic signed [31:0]    out_rate_z_o,
  output logic signed [31:0]    out_orient_w_o,
  output logic signed [31:0]    out_orient_x_o,
  output logic signed [31:0]    out_orient_y_o,
  output logic signed [31:0]    out_orient_z_o,
  output logic                  is_leveled_o
);

  // configuration registers
  logic [MIN_W-1:0] min_q;
  logic [DUR_W-1:0] dur_q;
  logic             pass_q;

  // sequencer state
  state_e     state_q, state_d;
  logic [1:0] row_q, row_d;
  logic [2:0] term_q, term_d;
  logic [3:0] ent_q, ent_d;
  logic       vsel_q, vsel_d;

  // calibration state
  logic                  leveled_q;
  logic [STAMP_BITS-1:0] first_q;
  logic [COUNT_BITS-1:0] count_q;
  logic [SUM_W-1:0]      sum_q [3];
  logic signed [31:0]    mat_q [9];
  logic signed [31:0]    lq_q  [3];   // level quaternion w, x, y (z stays zero)

  // latched item
  logic                  op_q;
  logic [STAMP_BITS-1:0] stamp_q;
  logic signed [31:0]    v_q [3];
  logic signed [31:0]    g_q [3];
  logic signed [31:0]    b_q [4];

  // leveling scratch
  logic [SUM_W-1:0]   m_q [3];
  logic [2:0]         neg_q;
  logic [SUM_W-1:0]   top_q;
  logic signed [32:0] qv_q [3];
  logic [31:0]        len_q;

  // results
  logic signed [31:0] rv_q [3];
  logic signed [31:0] rg_q [3];
  logic signed [32:0] r_q  [4];
  logic signed [31:0] ro_q [4];

  // output register
  logic               out_valid_q;
  logic               kind_q, lvl_out_q;
  logic signed [31:0] ox_q [3];
  logic signed [31:0] orate_q [3];
  logic signed [31:0] oori_q [4];

  // shared units
  mac_ctl_t                mac_ctl;
  logic signed [MUL_W-1:0] mac_a, mac_b;
  logic signed [ACC_W-1:0] acc;
  logic                    sq_start, sq_done, dv_start, dv_done;
  logic [31:0]             sq_res, dv_quo;
  logic [63:0]             dv_num;

  gvl_mac u_mac (
    .clk_i (clk_i),
    .ctl_i (mac_ctl),
    .a_i   (mac_a),
    .b_i   (mac_b),
    .acc_o (acc)
  );

  gvl_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .arg_i   (acc[63:0]),
    .root_o  (sq_res),
    .done_o  (sq_done)
  );

  gvl_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .num_i   (dv_num),
    .den_i   (len_q),
    .quo_o   (dv_quo),
    .done_o  (dv_done)
  );

  // handshakes
  logic in_fire, cfg_fire, out_free;
  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // level condition, checked after the sample has been added
  logic [STAMP_BITS-1:0] elapsed;
  logic                  lvl_cond, sum_zero;
  always_comb begin
    elapsed  = stamp_q - first_q;
    lvl_cond = (32'(count_q) >= 32'(min_q)) && (stamp_q >= first_q) &&
               (64'(elapsed) >= 64'(dur_q));
    sum_zero = (sum_q[0] == '0) && (sum_q[1] == '0) && (sum_q[2] == '0);
  end

  // sum magnitudes and their maximum
  logic [SUM_W-1:0] mag [3];
  logic [SUM_W-1:0] top01;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag[i] = sum_q[i][SUM_W-1] ? (~sum_q[i] + 1'b1) : sum_q[i];
    end
    top01 = (mag[0] > mag[1]) ? mag[0] : mag[1];
  end

  // normalizing shift: leading one of the largest magnitude lands on bit 28
  logic norm_hi, norm_lo, anti;
  assign norm_hi = |top_q[SUM_W-1:29];
  assign norm_lo = !top_q[28];
  assign anti    = (m_q[0][28:0] == '0) && (m_q[1][28:0] == '0) && neg_q[2];

  // signed scaled sums
  logic signed [32:0] sc [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sc[i] = neg_q[i] ? -$signed({4'b0, m_q[i][28:0]}) : $signed({4'b0, m_q[i][28:0]});
    end
  end

  // term selection
  mat_term_t  mt;
  prod_term_t pt;
  logic [3:0] mat_idx;
  always_comb begin
    mt      = mat_term(ent_q, term_q[0]);
    pt      = prod_term(row_q, term_q[1:0]);
    mat_idx = {1'b0, row_q, 1'b0} + {2'b0, row_q} + {2'b0, term_q[1:0]};
  end

  function automatic logic signed [32:0] qval(qsel_e s, logic signed [31:0] w,
                                              logic signed [31:0] x, logic signed [31:0] y);
    logic signed [32:0] r;
    unique case (s)
      Q_W:     r = 33'(w);
      Q_X:     r = 33'(x);
      Q_Y:     r = 33'(y);
      default: r = '0;
    endcase
    return r;
  endfunction

  // rounding of the accumulator
  logic signed [ACC_W-1:0] rnd30, rnd29;
  logic signed [31:0]      sat30, mat_val;
  always_comb begin
    rnd30 = (acc + (ACC_W'(1) <<< 29)) >>> 30;
    rnd29 = (acc + (ACC_W'(1) <<< 28)) >>> 29;
    if (!rnd30[ACC_W-1] && (|rnd30[ACC_W-2:31])) begin
      sat30 = 32'sh7fff_ffff;
    end else if (rnd30[ACC_W-1] && !(&rnd30[ACC_W-2:31])) begin
      sat30 = 32'sh8000_0000;
    end else begin
      sat30 = rnd30[31:0];
    end
    if (ent_q == 4'd0 || ent_q == 4'd4 || ent_q == 4'd8) begin
      mat_val = ONE_Q30 - rnd29[31:0];
    end else begin
      mat_val = rnd29[31:0];
    end
  end

  // divider operand: magnitude shifted into Q2.30 plus half the divisor
  logic signed [32:0] div_c;
  logic [32:0]        div_mag;
  logic signed [31:0] div_res;
  always_comb begin
    div_c   = (state_q == S_ODIV) ? r_q[row_q] : qv_q[row_q];
    div_mag = div_c[32] ? 33'(-div_c) : 33'(div_c);
    dv_num  = (64'(div_mag) << 30) + 64'(len_q[31:1]);
    div_res = div_c[32] ? -$signed(dv_quo) : $signed(dv_quo);
  end

  logic [63:0] acc_u;
  assign acc_u = acc[63:0];

  // next state and unit control
  always_comb begin
    state_d  = state_q;
    row_d    = row_q;
    term_d   = term_q;
    ent_d    = ent_q;
    vsel_d   = vsel_q;
    mac_ctl  = '0;
    mac_a    = '0;
    mac_b    = '0;
    sq_start = 1'b0;
    dv_start = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          row_d  = '0;
          term_d = '0;
          ent_d  = '0;
          vsel_d = 1'b0;
          if (op_i == OP_POINT) begin
            state_d = (!leveled_q && !pass_q) ? S_IDLE : S_ROT;
          end else begin
            state_d = leveled_q ? S_ROT : S_ACCUM;
          end
        end
      end
      S_ACCUM: state_d = S_CHECK;
      S_CHECK: begin
        if (lvl_cond) begin
          state_d = sum_zero ? S_IDLE : S_MAX;
        end else begin
          state_d = pass_q ? S_ROT : S_IDLE;
        end
      end
      S_MAX: state_d = S_NORM;
      S_NORM: begin
        if (!norm_hi && !norm_lo) begin
          state_d = anti ? S_SIGN : S_SQ;
          term_d  = '0;
        end
      end
      S_SQ, S_LSQ: begin
        mac_ctl = '{en: 1'b1, clr: (term_q == 3'd0), neg: 1'b0};
        mac_a   = (state_q == S_SQ) ? sc[term_q[1:0]] : qv_q[term_q[1:0]];
        mac_b   = mac_a;
        if (term_q == 3'd2) begin
          state_d = (state_q == S_SQ) ? S_SQRT_N : S_SQRT_L;
          term_d  = '0;
        end else begin
          term_d = term_q + 3'd1;
        end
      end
      S_SQRT_N, S_SQRT_L, S_SQRT_O: begin
        if (term_q == 3'd0) begin
          sq_start = 1'b1;
          term_d   = 3'd1;
        end else if (sq_done) begin
          term_d = '0;
          row_d  = '0;
          priority case (state_q)
            S_SQRT_N: state_d = S_LSQ;
            S_SQRT_L: state_d = S_QDIV;
            default:  state_d = (sq_res == '0) ? S_FINISH : S_ODIV;
          endcase
        end
      end
      S_QDIV, S_ODIV: begin
        if (term_q == 3'd0) begin
          dv_start = 1'b1;
          term_d   = 3'd1;
        end else if (dv_done) begin
          term_d = '0;
          row_d  = row_q + 2'd1;
          if (state_q == S_QDIV && row_q == 2'd2) begin
            state_d = S_SIGN;
          end else if (state_q == S_ODIV && row_q == 2'd3) begin
            state_d = S_FINISH;
          end
        end
      end
      S_SIGN: begin
        state_d = S_MAT;
        ent_d   = '0;
        term_d  = '0;
      end
      S_MAT: begin
        if (term_q == 3'd2) begin
          term_d = '0;
          if (ent_q == 4'd8) begin
            state_d = S_ROT;
            row_d   = '0;
            vsel_d  = 1'b0;
          end else begin
            ent_d = ent_q + 4'd1;
          end
        end else begin
          mac_ctl = '{en: 1'b1, clr: (term_q == 3'd0), neg: mt.neg};
          mac_a   = qval(mt.a, lq_q[0], lq_q[1], lq_q[2]);
          mac_b   = qval(mt.b, lq_q[0], lq_q[1], lq_q[2]);
          term_d  = term_q + 3'd1;
        end
      end
      S_ROT: begin
        if (term_q == 3'd3) begin
          term_d = '0;
          if (row_q == 2'd2) begin
            row_d = '0;
            if (vsel_q) begin
              state_d = S_OTOT;
            end else if (op_q == OP_POINT) begin
              state_d = S_FINISH;
            end else begin
              vsel_d = 1'b1;
            end
          end else begin
            row_d = row_q + 2'd1;
          end
        end else begin
          mac_ctl = '{en: 1'b1, clr: (term_q == 3'd0), neg: 1'b0};
          mac_a   = 33'(mat_q[mat_idx]);
          mac_b   = vsel_q ? 33'(g_q[term_q[1:0]]) : 33'(v_q[term_q[1:0]]);
          term_d  = term_q + 3'd1;
        end
      end
      S_OTOT: begin
        mac_a = 33'(b_q[term_q[1:0]]);
        mac_b = mac_a;
        if (term_q == 3'd4) begin
          if (acc_u <= NORM_LOW || acc_u >= NORM_HIGH) begin
            state_d = S_FINISH;
          end else begin
            state_d = S_OPROD;
            row_d   = '0;
            term_d  = '0;
          end
        end else if (term_q == 3'd3 && acc_u >= NORM_HIGH) begin
          state_d = S_FINISH;
        end else begin
          mac_ctl = '{en: 1'b1, clr: (term_q == 3'd0), neg: 1'b0};
          term_d  = term_q + 3'd1;
        end
      end
      S_OPROD: begin
        if (term_q == 3'd3) begin
          term_d = '0;
          row_d  = row_q + 2'd1;
          if (row_q == 2'd3) begin
            state_d = S_ONSQ;
          end
        end else begin
          mac_ctl = '{en: 1'b1, clr: (term_q == 3'd0), neg: pt.neg};
          mac_a   = 33'(lq_q[term_q[1:0]]);
          mac_b   = 33'(b_q[pt.bidx]);
          term_d  = term_q + 3'd1;
        end
      end
      S_ONSQ: begin
        mac_ctl = '{en: 1'b1, clr: (term_q == 3'd0), neg: 1'b0};
        mac_a   = r_q[term_q[1:0]];
        mac_b   = mac_a;
        if (term_q == 3'd3) begin
          state_d = S_SQRT_O;
          term_d  = '0;
        end else begin
          term_d = term_q + 3'd1;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= '0;
      term_q      <= '0;
      ent_q       <= '0;
      vsel_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      term_q  <= term_d;
      ent_q   <= ent_d;
      vsel_q  <= vsel_d;
      if (state_q == S_FINISH && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // configuration and calibration state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q     <= MIN_SAMPLES_RST;
      dur_q     <= CALIB_DURATION_RST;
      pass_q    <= 1'b0;
      leveled_q <= 1'b0;
      first_q   <= '0;
      count_q   <= '0;
      for (int i = 0; i < 3; i++) begin
        sum_q[i] <= '0;
      end
      for (int i = 0; i < 9; i++) begin
        mat_q[i] <= (i % 4 == 0) ? ONE_Q30 : '0;
      end
      lq_q[0] <= ONE_Q30;
      lq_q[1] <= '0;
      lq_q[2] <= '0;
    end else begin
      if (cfg_fire) begin
        unique case (cfg_index_i)
          REG_MIN_SAMPLES:    min_q  <= cfg_data_i[MIN_W-1:0];
          REG_CALIB_DURATION: dur_q  <= cfg_data_i[DUR_W-1:0];
          REG_PASS_BEFORE:    pass_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      // accumulation freezes once the count saturates
      if (state_q == S_ACCUM && !(&count_q)) begin
        if (count_q == '0) begin
          first_q <= stamp_q;
        end
        for (int i = 0; i < 3; i++) begin
          sum_q[i] <= sum_q[i] + {{(SUM_W-32){v_q[i][31]}}, v_q[i]};
        end
        count_q <= count_q + 1'b1;
      end
      // antiparallel: half turn about x
      if (state_q == S_NORM && !norm_hi && !norm_lo && anti) begin
        lq_q[0] <= '0;
        lq_q[1] <= ONE_Q30;
        lq_q[2] <= '0;
      end
      if (state_q == S_QDIV && term_q != 3'd0 && dv_done) begin
        lq_q[row_q] <= div_res;
      end
      // sign convention for small w
      if (state_q == S_SIGN && lq_q[0] <= $signed(HALF_Q30)) begin
        if ((lq_q[1][31] ? -lq_q[1] : lq_q[1]) >= (lq_q[2][31] ? -lq_q[2] : lq_q[2])) begin
          if (lq_q[1][31]) begin
            for (int i = 0; i < 3; i++) lq_q[i] <= -lq_q[i];
          end
        end else if (lq_q[2][31]) begin
          for (int i = 0; i < 3; i++) lq_q[i] <= -lq_q[i];
        end
      end
      if (state_q == S_MAT && term_q == 3'd2) begin
        mat_q[ent_q] <= mat_val;
        if (ent_q == 4'd8) begin
          leveled_q <= 1'b1;
        end
      end
    end
  end

  // item and scratch datapath
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      op_q    <= op_i;
      stamp_q <= stamp_i;
      v_q[0]  <= vec_x_i;
      v_q[1]  <= vec_y_i;
      v_q[2]  <= vec_z_i;
      g_q[0]  <= rate_x_i;
      g_q[1]  <= rate_y_i;
      g_q[2]  <= rate_z_i;
      b_q[0]  <= orient_w_i;
      b_q[1]  <= orient_x_i;
      b_q[2]  <= orient_y_i;
      b_q[3]  <= orient_z_i;
    end
    if (state_q == S_MAX) begin
      for (int i = 0; i < 3; i++) begin
        m_q[i]   <= mag[i];
        neg_q[i] <= sum_q[i][SUM_W-1];
      end
      top_q <= (top01 > mag[2]) ? top01 : mag[2];
    end
    if (state_q == S_NORM) begin
      if (norm_hi) begin
        for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] >> 1;
        top_q <= top_q >> 1;
      end else if (norm_lo) begin
        for (int i = 0; i < 3; i++) m_q[i] <= m_q[i] << 1;
        top_q <= top_q << 1;
      end
    end
    if (state_q == S_SQRT_N && term_q != 3'd0 && sq_done) begin
      qv_q[0] <= $signed({1'b0, sq_res}) + sc[2];
      qv_q[1] <= sc[1];
      qv_q[2] <= -sc[0];
    end
    if ((state_q == S_SQRT_L || state_q == S_SQRT_O) && term_q != 3'd0 && sq_done) begin
      len_q <= sq_res;
    end
    if (state_q == S_ROT && term_q == 3'd3) begin
      if (vsel_q) begin
        rg_q[row_q] <= sat30;
      end else begin
        rv_q[row_q] <= sat30;
      end
    end
    // orientation defaults to an echo until the normalize finishes
    if (state_q == S_OTOT && term_q == 3'd0) begin
      for (int i = 0; i < 4; i++) ro_q[i] <= b_q[i];
    end
    if (state_q == S_OPROD && term_q == 3'd3) begin
      r_q[row_q] <= rnd30[32:0];
    end
    if (state_q == S_ODIV && term_q != 3'd0 && dv_done) begin
      ro_q[row_q] <= div_res;
    end
    // output register load
    if (state_q == S_FINISH && out_free) begin
      kind_q    <= op_q;
      lvl_out_q <= leveled_q;
      for (int i = 0; i < 3; i++) begin
        ox_q[i]    <= rv_q[i];
        orate_q[i] <= (op_q == OP_POINT) ? '0 : rg_q[i];
      end
      for (int i = 0; i < 4; i++) begin
        oori_q[i] <= (op_q == OP_POINT) ? '0 : ro_q[i];
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign kind_o         = kind_q;
  assign out_x_o        = ox_q[0];
  assign out_y_o        = ox_q[1];
  assign out_z_o        = ox_q[2];
  assign out_rate_x_o   = orate_q[0];
  assign out_rate_y_o   = orate_q[1];
  assign out_rate_z_o   = orate_q[2];
  assign out_orient_w_o = oori_q[0];
  assign out_orient_x_o = oori_q[1];
  assign out_orient_y_o = oori_q[2];
  assign out_orient_z_o = oori_q[3];
  assign is_leveled_o   = lvl_out_q;

endmodule

// ----- tb/sv/gravity_level_calibrate_rotate_tb.sv -----
// self-checking bench for the gravity leveling block: drops, pass-through, calibration, rotation
// depends on gvl_pkg and gravity_level_calibrate_rotate; carries its own bit-exact predictor
module gravity_level_calibrate_rotate_tb;
  import gvl_pkg::*;

  localparam longint UNIT      = longint'(ONE_Q30);
  localparam longint HALF      = longint'(HALF_Q30);
  localparam int     SETTLE    = 600;   // covers the sample that triggers calibration
  localparam int     HOLD_CYC  = 400;   // long receiver hold-off
  localparam longint GRAV      = 642252; // about 9.8 in Q16.16

  // one input item and one result item
  typedef struct {
    logic               op;
    logic [47:0]        stamp;
    logic signed [31:0] vec[3];
    logic signed [31:0] rate[3];
    logic signed [31:0] ori[4];
  } sample_t;

  typedef struct {
    logic               kind;
    logic signed [31:0] pos[3];
    logic signed [31:0] rate[3];
    logic signed [31:0] ori[4];
    logic               lev;
  } level_out_t;

  logic                  clk_i, rst_ni;
  logic                  cfg_valid_i, cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  in_valid_i, in_ready_o, op_i;
  logic [47:0]           stamp_i;
  logic signed [31:0]    vec_x_i, vec_y_i, vec_z_i, rate_x_i, rate_y_i, rate_z_i;
  logic signed [31:0]    orient_w_i, orient_x_i, orient_y_i, orient_z_i;
  logic                  out_valid_o, out_ready_i, kind_o, is_leveled_o;
  logic signed [31:0]    out_x_o, out_y_o, out_z_o, out_rate_x_o, out_rate_y_o, out_rate_z_o;
  logic signed [31:0]    out_orient_w_o, out_orient_x_o, out_orient_y_o, out_orient_z_o;

  gravity_level_calibrate_rotate u_top (.*);

  // predictor copy of the block state and registers
  logic               lev_done;
  logic [47:0]        first_ts;
  logic [23:0]        n_samp;
  logic [55:0]        grav_sum[3];
  logic signed [31:0] lev_mat[9];
  logic signed [31:0] lev_q[4];
  logic [23:0]        cfg_min;
  logic [39:0]        cfg_dur;
  logic               cfg_pass;

  level_out_t pending_q[$];
  int         errors, items_in, results_seen, calib_mode;
  bit         calm, hold_req, hold_on;
  int         stall_left;

  // clock and timeout
  initial clk_i = 1'b0;
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #40_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // ---------------------------------------------------------------- arithmetic

  function automatic longint rnd_sh(longint v, int k);
    return (v + (longint'(1) <<< (k - 1))) >>> k;
  endfunction

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return v[31:0];
  endfunction

  // c / len in Q2.30, half away from zero
  function automatic logic signed [31:0] unit_q30(longint c, longint unsigned len);
    longint unsigned m, r;
    m = (c < 0) ? -c : c;
    r = ((m << 30) + len / 2) / len;
    return (c < 0) ? -$signed(r[31:0]) : $signed(r[31:0]);
  endfunction

  function automatic void turn(input longint v[3], output logic signed [31:0] r[3]);
    longint acc;
    for (int i = 0; i < 3; i++) begin
      acc = longint'(lev_mat[i*3]) * v[0] + longint'(lev_mat[i*3+1]) * v[1] +
            longint'(lev_mat[i*3+2]) * v[2];
      r[i] = sat32(rnd_sh(acc, 30));
    end
  endfunction

  function automatic void build_mat();
    longint w, x, y, z;
    w = lev_q[0]; x = lev_q[1]; y = lev_q[2]; z = lev_q[3];
    lev_mat[0] = UNIT - rnd_sh(y*y + z*z, 29);
    lev_mat[1] = rnd_sh(x*y - w*z, 29);
    lev_mat[2] = rnd_sh(x*z + w*y, 29);
    lev_mat[3] = rnd_sh(x*y + w*z, 29);
    lev_mat[4] = UNIT - rnd_sh(x*x + z*z, 29);
    lev_mat[5] = rnd_sh(y*z - w*x, 29);
    lev_mat[6] = rnd_sh(x*z - w*y, 29);
    lev_mat[7] = rnd_sh(y*z + w*x, 29);
    lev_mat[8] = UNIT - rnd_sh(x*x + y*y, 29);
  endfunction

  // minimal rotation taking the summed gravity direction onto +z
  function automatic void level_from_sum();
    longint s[3], sc[3], qw, qx, qy;
    longint unsigned m[3], a[3], top, nn, len;
    logic signed [31:0] ax, ay, pick;
    int p;
    top = 0;
    for (int i = 0; i < 3; i++) begin
      s[i] = longint'($signed(grav_sum[i]));
      m[i] = (s[i] < 0) ? -s[i] : s[i];
      if (m[i] > top) top = m[i];
    end
    p = 0;
    while ((top >> p) > 1) p++;
    for (int i = 0; i < 3; i++) begin
      a[i] = (p > 28) ? (m[i] >> (p - 28)) : (m[i] << (28 - p));
      sc[i] = (s[i] < 0) ? -longint'(a[i]) : longint'(a[i]);
    end
    if (sc[0] == 0 && sc[1] == 0 && sc[2] < 0) begin
      // gravity straight down the wrong way: half turn about x
      lev_q[0] = 0; lev_q[1] = UNIT; lev_q[2] = 0; lev_q[3] = 0;
    end else begin
      nn  = isqrt(a[0]*a[0] + a[1]*a[1] + a[2]*a[2]);
      qw  = longint'(nn) + sc[2];
      qx  = sc[1];
      qy  = -sc[0];
      len = isqrt(qw*qw + qx*qx + qy*qy);
      lev_q[0] = unit_q30(qw, len);
      lev_q[1] = unit_q30(qx, len);
      lev_q[2] = unit_q30(qy, len);
      lev_q[3] = 0;
    end
    if (longint'(lev_q[0]) <= HALF) begin
      ax = (lev_q[1] < 0) ? -lev_q[1] : lev_q[1];
      ay = (lev_q[2] < 0) ? -lev_q[2] : lev_q[2];
      pick = (ax >= ay) ? lev_q[1] : lev_q[2];
      if (pick < 0)
        for (int i = 0; i < 4; i++) lev_q[i] = -lev_q[i];
    end
    build_mat();
    lev_done = 1'b1;
  endfunction

  function automatic void orient_pred(input logic signed [31:0] q[4],
                                      output logic signed [31:0] o[4]);
    longint b[4], pr[4], r[4], aw, ax, ay, az;
    longint unsigned tot, nsq, len;
    for (int i = 0; i < 4; i++) begin
      b[i] = q[i];
      o[i] = q[i];
    end
    tot = b[0]*b[0] + b[1]*b[1] + b[2]*b[2];
    if (tot >= NORM_HIGH) return;
    tot = tot + b[3]*b[3];
    if (tot <= NORM_LOW || tot >= NORM_HIGH) return;
    aw = lev_q[0]; ax = lev_q[1]; ay = lev_q[2]; az = lev_q[3];
    pr[0] = aw*b[0] - ax*b[1] - ay*b[2] - az*b[3];
    pr[1] = aw*b[1] + ax*b[0] + ay*b[3] - az*b[2];
    pr[2] = aw*b[2] - ax*b[3] + ay*b[0] + az*b[1];
    pr[3] = aw*b[3] + ax*b[2] - ay*b[1] + az*b[0];
    nsq = 0;
    for (int i = 0; i < 4; i++) begin
      r[i] = rnd_sh(pr[i], 30);
      nsq = nsq + r[i]*r[i];
    end
    len = isqrt(nsq);
    if (len == 0) return;
    for (int i = 0; i < 4; i++) o[i] = unit_q30(r[i], len);
  endfunction

  // advance the predictor by one accepted item; returns 1 when a result follows
  function automatic bit level_predict(input sample_t it, output level_out_t r);
    longint v[3], g[3];
    r.kind = it.op;
    for (int i = 0; i < 3; i++) begin
      v[i] = it.vec[i];
      g[i] = it.rate[i];
      r.pos[i] = 0;
      r.rate[i] = 0;
    end
    for (int i = 0; i < 4; i++) r.ori[i] = 0;
    if (it.op == OP_POINT) begin
      if (!lev_done && !cfg_pass) return 0;
      if (lev_done) turn(v, r.pos);
      else for (int i = 0; i < 3; i++) r.pos[i] = it.vec[i];
    end else begin
      if (!lev_done) begin
        if (n_samp != 24'hFF_FFFF) begin
          if (n_samp == 0) first_ts = it.stamp;
          for (int i = 0; i < 3; i++)
            grav_sum[i] = grav_sum[i] + {{24{it.vec[i][31]}}, it.vec[i]};
          n_samp = n_samp + 1;
        end
        if (n_samp >= cfg_min && it.stamp >= first_ts &&
            (it.stamp - first_ts) >= {8'd0, cfg_dur}) begin
          // zero sum: no calibration and nothing comes out
          if (grav_sum[0] == 0 && grav_sum[1] == 0 && grav_sum[2] == 0) return 0;
          level_from_sum();
        end
        if (!lev_done && !cfg_pass) return 0;
      end
      turn(v, r.pos);
      turn(g, r.rate);
      orient_pred(it.ori, r.ori);
    end
    r.lev = lev_done;
    return 1;
  endfunction

  // ---------------------------------------------------------------- stimulus helpers

  function automatic logic signed [31:0] edge32();
    case ($urandom_range(0, 7))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 0;
      3: return -1;
      4: return 1;
      default: return $signed($urandom);
    endcase
  endfunction

  // roughly unit quaternion component, so the norm test usually passes
  function automatic logic signed [31:0] unitish();
    return $signed($urandom_range(0, 32'h7fff_ffff)) - 32'sh4000_0000;
  endfunction

  function automatic sample_t rnd_sample(logic op, bit wild);
    sample_t s;
    s.op = op;
    s.stamp = {$urandom, $urandom};
    for (int i = 0; i < 3; i++) begin
      s.vec[i]  = wild ? edge32() : $signed($urandom_range(0, 32'h1f_ffff)) - 32'sh10_0000;
      s.rate[i] = wild ? edge32() : $signed($urandom);
    end
    for (int i = 0; i < 4; i++) s.ori[i] = wild ? edge32() : unitish();
    return s;
  endfunction

  task automatic report(string what, longint expv, longint gotv);
    $display("mismatch %s: expected %0h got %0h at %0t", what, expv, gotv, $realtime);
    errors++;
  endtask

  task automatic push_item(input sample_t it);
    level_out_t r;
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 0;
    @(negedge clk_i);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    op_i <= it.op;
    stamp_i <= it.stamp;
    vec_x_i <= it.vec[0];  vec_y_i <= it.vec[1];  vec_z_i <= it.vec[2];
    rate_x_i <= it.rate[0]; rate_y_i <= it.rate[1]; rate_z_i <= it.rate[2];
    orient_w_i <= it.ori[0]; orient_x_i <= it.ori[1];
    orient_y_i <= it.ori[2]; orient_z_i <= it.ori[3];
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    items_in++;
    if (level_predict(it, r)) pending_q.push_back(r);
  endtask

  // stop offering, wait for every expected result, then let dropped work finish
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_MIN_SAMPLES:    cfg_min  = val[23:0];
      REG_CALIB_DURATION: cfg_dur  = val[39:0];
      REG_PASS_BEFORE:    cfg_pass = val[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // ---------------------------------------------------------------- receiver side

  // long hold-off, counted here
  initial begin
    hold_on = 1'b0;
    forever begin
      wait (hold_req);
      hold_on = 1'b1;
      repeat (HOLD_CYC) @(negedge clk_i);
      hold_on = 1'b0;
      hold_req = 1'b0;
    end
  end

  // random stall bursts
  always @(negedge clk_i) begin
    if (hold_on) begin
      out_ready_i <= 1'b0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin
    level_out_t e;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        report("result with nothing expected, kind", 0, kind_o);
      end else begin
        e = pending_q.pop_front();
        if (kind_o !== e.kind) report("kind", e.kind, kind_o);
        if (out_x_o !== e.pos[0]) report("out_x", e.pos[0], out_x_o);
        if (out_y_o !== e.pos[1]) report("out_y", e.pos[1], out_y_o);
        if (out_z_o !== e.pos[2]) report("out_z", e.pos[2], out_z_o);
        if (out_rate_x_o !== e.rate[0]) report("out_rate_x", e.rate[0], out_rate_x_o);
        if (out_rate_y_o !== e.rate[1]) report("out_rate_y", e.rate[1], out_rate_y_o);
        if (out_rate_z_o !== e.rate[2]) report("out_rate_z", e.rate[2], out_rate_z_o);
        if (out_orient_w_o !== e.ori[0]) report("out_orient_w", e.ori[0], out_orient_w_o);
        if (out_orient_x_o !== e.ori[1]) report("out_orient_x", e.ori[1], out_orient_x_o);
        if (out_orient_y_o !== e.ori[2]) report("out_orient_y", e.ori[2], out_orient_y_o);
        if (out_orient_z_o !== e.ori[3]) report("out_orient_z", e.ori[3], out_orient_z_o);
        if (is_leveled_o !== e.lev) report("is_leveled", e.lev, is_leveled_o);
      end
    end
  end

  // ---------------------------------------------------------------- tests

  // reset registers drop everything before calibration; the first sample fixes the start time
  task automatic test_drop_default();
    sample_t s;
    s = rnd_sample(OP_IMU, 0);
    s.stamp = 48'h4000_0000_0000;
    push_item(s);
    push_item(rnd_sample(OP_POINT, 1));
    drain();
  endtask

  // items pass unrotated; field extremes and the orientation norm window
  task automatic test_pass_directed();
    sample_t s;
    set_reg(REG_MIN_SAMPLES, 40'hFF_FFFF);
    set_reg(REG_CALIB_DURATION, 40'hFF_FFFF_FFFF);
    set_reg(REG_PASS_BEFORE, 40'd1);
    for (int k = 0; k < 4; k++) begin
      s = rnd_sample(OP_POINT, 0);
      for (int i = 0; i < 3; i++)
        s.vec[i] = (k == 0) ? 32'sh7fff_ffff : (k == 1) ? 32'sh8000_0000 : (k == 2) ? 0 : -1;
      push_item(s);
    end
    for (int k = 0; k < 10; k++) begin
      s = rnd_sample(OP_IMU, 1);
      s.stamp = (k == 0) ? 48'hFFFF_FFFF_FFFF : (k == 1) ? 48'd0 : s.stamp;
      for (int i = 0; i < 4; i++) s.ori[i] = 0;
      case (k)
        0: s.ori[0] = UNIT;                        // identity
        1: s.ori[0] = HALF;                        // norm exactly 0.5: echoed
        2: s.ori[0] = HALF + 1;                    // just inside
        3: s.ori[0] = 3 * HALF;                    // norm exactly 1.5: echoed
        4: s.ori[0] = 3 * HALF - 1;                // just inside
        5: for (int i = 0; i < 4; i++) s.ori[i] = 32'sh8000_0000;
        6: for (int i = 0; i < 4; i++) s.ori[i] = 32'sh7fff_ffff;
        7: s.ori[3] = -UNIT;                       // only z counts toward the norm
        8: for (int i = 0; i < 4; i++) s.ori[i] = unitish();
        default: ;                                 // zero quaternion
      endcase
      for (int i = 0; i < 3; i++) s.rate[i] = (k % 2) ? 32'sh8000_0000 : 32'sh7fff_ffff;
      push_item(s);
    end
    drain();
  endtask

  // random traffic before calibration, pass on and off
  task automatic test_unleveled_random();
    for (int ph = 0; ph < 4; ph++) begin
      set_reg(REG_PASS_BEFORE, (ph % 2) ? 40'd0 : 40'd1);
      for (int n = 0; n < 30; n++)
        push_item(rnd_sample($urandom_range(0, 1), $urandom_range(0, 3) == 0));
      drain();
    end
  endtask

  // bring the gravity sums back to zero for the zero-sum case
  task automatic test_cancel_sum();
    sample_t s;
    longint r;
    set_reg(REG_PASS_BEFORE, 40'd1);
    while (grav_sum[0] != 0 || grav_sum[1] != 0 || grav_sum[2] != 0) begin
      s = rnd_sample(OP_IMU, 0);
      for (int i = 0; i < 3; i++) begin
        r = -longint'($signed(grav_sum[i]));
        s.vec[i] = (r > 64'sd2147483647) ? 32'sh7fff_ffff :
                   (r < -64'sd2147483648) ? 32'sh8000_0000 : r[31:0];
      end
      push_item(s);
    end
    drain();
  endtask

  // conditions met but the sum is zero: nothing out, with pass off and on
  task automatic test_zero_sum();
    sample_t s;
    set_reg(REG_MIN_SAMPLES, 40'd0);
    set_reg(REG_CALIB_DURATION, 40'd0);
    for (int k = 0; k < 2; k++) begin
      set_reg(REG_PASS_BEFORE, k);
      s = rnd_sample(OP_IMU, 0);
      s.stamp = first_ts + k;
      for (int i = 0; i < 3; i++) s.vec[i] = 0;
      push_item(s);
      push_item(rnd_sample(OP_POINT, 1));
      drain();
    end
  endtask

  function automatic sample_t grav_sample(logic [47:0] st, longint g[3]);
    sample_t s;
    s = rnd_sample(OP_IMU, 0);
    s.stamp = st;
    for (int i = 0; i < 3; i++) s.vec[i] = g[i];
    return s;
  endfunction

  // calibration: a sample earlier than the start time, one too soon, then the trigger
  task automatic test_calibrate();
    longint g[3];
    calib_mode = $urandom_range(0, 2);
    if (calib_mode == 0) begin
      g[0] = 0; g[1] = 0; g[2] = -GRAV;            // upside down
    end else begin
      for (int i = 0; i < 3; i++) g[i] = longint'($urandom_range(0, 2 * GRAV)) - GRAV;
      if (g[2] == 0) g[2] = GRAV;
    end
    push_item(grav_sample(first_ts - 48'd1, g)); // time ran backwards: not reached
    drain();
    set_reg(REG_MIN_SAMPLES, 40'd5);
    set_reg(REG_CALIB_DURATION, 40'd1000);
    push_item(grav_sample(first_ts + 48'd500, g));
    push_item(grav_sample(first_ts + 48'd1000, g));
    drain();
  endtask

  // leveled traffic, mostly points and well-formed samples
  task automatic test_leveled_random();
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: set_reg(REG_MIN_SAMPLES, 40'hFF_FFFF);
        1: set_reg(REG_CALIB_DURATION, 40'd0);
        default: set_reg(REG_PASS_BEFORE, 40'd0);
      endcase
      for (int n = 0; n < 280; n++)
        push_item(rnd_sample($urandom_range(0, 9) < 6 ? OP_POINT : OP_IMU,
                             $urandom_range(0, 4) == 0));
      drain();
    end
  endtask

  // receiver holds off while the sender keeps offering, then a full pause
  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int n = 0; n < 24; n++)
      push_item(rnd_sample($urandom_range(0, 3) != 0 ? OP_POINT : OP_IMU, 0));
    drain();
  endtask

  task automatic test_calm_tail();
    calm = 1'b1;
    for (int n = 0; n < 40; n++)
      push_item(rnd_sample($urandom_range(0, 1), $urandom_range(0, 3) == 0));
    drain();
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_valid_i = 1'b0; cfg_index_i = '0; cfg_data_i = '0;
    in_valid_i = 1'b0; op_i = OP_POINT; stamp_i = '0;
    vec_x_i = 0; vec_y_i = 0; vec_z_i = 0;
    rate_x_i = 0; rate_y_i = 0; rate_z_i = 0;
    orient_w_i = 0; orient_x_i = 0; orient_y_i = 0; orient_z_i = 0;
    out_ready_i = 1'b0;
    stall_left = 0;
    calm = 1'b0;
    hold_req = 1'b0;
    errors = 0; items_in = 0; results_seen = 0;
    lev_done = 1'b0; first_ts = '0; n_samp = '0;
    for (int i = 0; i < 3; i++) grav_sum[i] = '0;
    for (int i = 0; i < 9; i++) lev_mat[i] = (i % 4 == 0) ? UNIT : 0;
    lev_q[0] = UNIT; lev_q[1] = 0; lev_q[2] = 0; lev_q[3] = 0;
    cfg_min = MIN_SAMPLES_RST; cfg_dur = CALIB_DURATION_RST; cfg_pass = 1'b0;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_drop_default();
    test_pass_directed();
    test_unleveled_random();
    test_cancel_sum();
    test_zero_sum();
    test_calibrate();
    test_leveled_random();
    test_backpressure();
    test_calm_tail();

    $display("%0d items in, %0d results checked, leveled %0b (calibration style %0d)",
             items_in, results_seen, lev_done, calib_mode);
    $display("covered drops, pass-through, zero sum, late start time, leveling and stalls");
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
